// ===== rtl/core/fpoc_pkg.sv =====
// Package: shared types, constants and register indexes for the keypoint mapper.
package fpoc_pkg;
  localparam int QuotWidth = 38;
  localparam int DivNumWidth = 42;
  localparam int DivDenWidth = 17;
  localparam int SqrtWidth = 48;
  localparam int SqrtSteps = 24;
  localparam int OutWidth = 26;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_FACE_INDEX = 3'd1,
    REG_IMAGE_WIDTH = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_SIZE_X = 3'd4,
    REG_SIZE_Y = 3'd5,
    REG_SIZE_Z = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic valid;
    logic flag;
    logic cyl;
    logic [2:0] face;
    logic [23:0] size_x;
    logic [23:0] offx;
    logic [23:0] offz;
  } ctl_t;
endpackage

// ===== rtl/core/fpoc_div_cell.sv =====
// One restoring-division step of a two-lane divider chain, with side-band pass-through.
module fpoc_div_cell #(
  parameter int Step = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  fpoc_pkg::ctl_t ctl_in,
  input  logic [fpoc_pkg::DivNumWidth-1:0] num_y_in,
  input  logic [fpoc_pkg::DivNumWidth-1:0] rem_y_in,
  input  logic [fpoc_pkg::DivDenWidth-1:0] den_y_in,
  input  logic neg_y_in,
  input  logic [fpoc_pkg::DivNumWidth-1:0] num_z_in,
  input  logic [fpoc_pkg::DivNumWidth-1:0] rem_z_in,
  input  logic [fpoc_pkg::DivDenWidth-1:0] den_z_in,
  input  logic neg_z_in,
  output fpoc_pkg::ctl_t ctl_out,
  output logic [fpoc_pkg::DivNumWidth-1:0] num_y_out,
  output logic [fpoc_pkg::DivNumWidth-1:0] rem_y_out,
  output logic [fpoc_pkg::DivDenWidth-1:0] den_y_out,
  output logic neg_y_out,
  output logic [fpoc_pkg::DivNumWidth-1:0] num_z_out,
  output logic [fpoc_pkg::DivNumWidth-1:0] rem_z_out,
  output logic [fpoc_pkg::DivDenWidth-1:0] den_z_out,
  output logic neg_z_out
);
  import fpoc_pkg::*;
  localparam int Bit = DivNumWidth - 1 - Step;
  logic [DivNumWidth:0] ty, tz;
  logic [DivNumWidth-1:0] ny, nz, ry, rz;

  always_comb begin
    ty = {rem_y_in, num_y_in[Bit]};
    tz = {rem_z_in, num_z_in[Bit]};
    ny = num_y_in;
    nz = num_z_in;
    ry = ty[DivNumWidth-1:0];
    rz = tz[DivNumWidth-1:0];
    if (ty >= {{(DivNumWidth-DivDenWidth+1){1'b0}}, den_y_in} && den_y_in != '0) begin
      ry = DivNumWidth'(ty - {{(DivNumWidth-DivDenWidth+1){1'b0}}, den_y_in});
      ny[Bit] = 1'b1;
    end else begin
      ny[Bit] = 1'b0;
    end
    if (tz >= {{(DivNumWidth-DivDenWidth+1){1'b0}}, den_z_in} && den_z_in != '0) begin
      rz = DivNumWidth'(tz - {{(DivNumWidth-DivDenWidth+1){1'b0}}, den_z_in});
      nz[Bit] = 1'b1;
    end else begin
      nz[Bit] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.flag <= ctl_in.flag;
      ctl_out.cyl <= ctl_in.cyl;
      ctl_out.face <= ctl_in.face;
      ctl_out.size_x <= ctl_in.size_x;
      ctl_out.offx <= ctl_in.offx;
      ctl_out.offz <= ctl_in.offz;
      num_y_out <= ny;
      rem_y_out <= ry;
      den_y_out <= den_y_in;
      neg_y_out <= neg_y_in;
      num_z_out <= nz;
      rem_z_out <= rz;
      den_z_out <= den_z_in;
      neg_z_out <= neg_z_in;
    end
  end
endmodule

// ===== rtl/core/fpoc_sqrt_cell.sv =====
// One digit step of the cylinder square-root chain, carrying y, z and control.
module fpoc_sqrt_cell #(
  parameter int Step = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  fpoc_pkg::ctl_t ctl_in,
  input  logic [fpoc_pkg::SqrtWidth-1:0] n_in,
  input  logic [fpoc_pkg::SqrtWidth-1:0] res_in,
  input  logic signed [fpoc_pkg::QuotWidth:0] ly_in,
  input  logic signed [fpoc_pkg::QuotWidth:0] lz_in,
  output fpoc_pkg::ctl_t ctl_out,
  output logic [fpoc_pkg::SqrtWidth-1:0] n_out,
  output logic [fpoc_pkg::SqrtWidth-1:0] res_out,
  output logic signed [fpoc_pkg::QuotWidth:0] ly_out,
  output logic signed [fpoc_pkg::QuotWidth:0] lz_out
);
  import fpoc_pkg::*;
  localparam logic [SqrtWidth-1:0] BitV = SqrtWidth'(1) << (SqrtWidth - 2 - 2 * Step);
  logic [SqrtWidth-1:0] nn, rn;

  always_comb begin
    nn = n_in;
    rn = res_in >> 1;
    if (n_in >= res_in + BitV) begin
      nn = n_in - (res_in + BitV);
      rn = (res_in >> 1) + BitV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.flag <= ctl_in.flag;
      ctl_out.cyl <= ctl_in.cyl;
      ctl_out.face <= ctl_in.face;
      ctl_out.size_x <= ctl_in.size_x;
      ctl_out.offx <= ctl_in.offx;
      ctl_out.offz <= ctl_in.offz;
      n_out <= nn;
      res_out <= rn;
      ly_out <= ly_in;
      lz_out <= lz_in;
    end
  end
endmodule

// ===== rtl/core/face_point_to_object_coords.sv =====
// Top level: keypoint (u,v) to object coordinates through divider and square-root cell chains.
// Usage:
//   Write the seven registers on cfg (cfg_index 0..6, cfg_data) while idle.
//   Send keypoints on s_axis (tdata = pixel_u, pixel_v); results leave on
//   m_axis (tdata = global_x, global_y, global_z; tuser = range_flag).
// Throughput: one keypoint per cycle while m_axis does not stall.
// Pipeline: stages 0-2, the 42 restoring-division cells (one quotient bit each),
//   the quotient stage, the 24 square-root cells (one root bit each), rotation and output.
// The whole pipe advances together; when m_axis stalls with a result held in
//   the output register every cell holds, and s_axis_tready drops.
// Reset clears the valid bits of all cells and loads the register defaults:
//   box, face 0, 640 by 480 pixels, all sizes zero.
// Items with zero image width or height give a zero local coordinate and set
//   range_flag; so do a negative radicand and any saturation.
module face_point_to_object_coords (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_u[15:0], pixel_v[31:16]
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [79:0] m_axis_tdata,   // global_x[25:0], global_y[51:26], global_z[77:52]
  output logic m_axis_tuser           // range_flag
);
  import fpoc_pkg::*;
  localparam int DivSteps = DivNumWidth;

  logic shape_mode;
  logic [2:0] face_index;
  logic [12:0] image_width, image_height;
  logic [23:0] size_x, size_y, size_z;
  logic en;

  assign cfg_ready = 1'b1;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode <= 1'b0;
      face_index <= 3'd0;
      image_width <= 13'd640;
      image_height <= 13'd480;
      size_x <= '0;
      size_y <= '0;
      size_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHAPE_MODE: shape_mode <= cfg_data[0];
        REG_FACE_INDEX: face_index <= cfg_data[2:0];
        REG_IMAGE_WIDTH: image_width <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        REG_SIZE_X: size_x <= cfg_data[23:0];
        REG_SIZE_Y: size_y <= cfg_data[23:0];
        REG_SIZE_Z: size_z <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // stage 0: centered offsets and side
  ctl_t c0;
  logic signed [17:0] du0, dv0;
  logic [24:0] side0;
  always_ff @(posedge clk) begin
    if (rst) begin
      c0.valid <= 1'b0;
    end else if (en) begin
      c0.valid <= s_axis_tvalid;
    end
    if (en) begin
      c0.flag <= (image_width == '0) || (image_height == '0);
      c0.cyl <= shape_mode;
      c0.face <= face_index;
      c0.size_x <= size_x;
      c0.offx <= shape_mode ? 24'd0 : {1'b0, size_x[23:1]};
      c0.offz <= shape_mode ? 24'd0 : {1'b0, size_z[23:1]};
      du0 <= $signed({2'b0, s_axis_tdata[15:0]}) - $signed({1'b0, image_width[12:1], 4'b0});
      dv0 <= $signed({2'b0, s_axis_tdata[31:16]}) - $signed({1'b0, image_height[12:1], 4'b0});
      side0 <= shape_mode ? {size_x, 1'b0} :
               ((face_index == 3'd0 || face_index == 3'd3) ? {1'b0, size_x} : {1'b0, size_z});
    end
  end

  // stage 1: magnitudes
  ctl_t c1;
  logic [16:0] adu1, adv1;
  logic ny1, nz1;
  logic [24:0] side1;
  logic [23:0] sy1;
  logic [16:0] dyw1, dzh1;
  logic [12:0] w0, h0;
  assign w0 = image_width;
  assign h0 = image_height;
  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid <= 1'b0;
    end else if (en) begin
      c1.valid <= c0.valid;
    end
    if (en) begin
      c1.flag <= c0.flag;
      c1.cyl <= c0.cyl;
      c1.face <= c0.face;
      c1.size_x <= c0.size_x;
      c1.offx <= c0.offx;
      c1.offz <= c0.offz;
      adu1 <= du0[17] ? 17'(-du0) : du0[16:0];
      adv1 <= dv0[17] ? 17'(-dv0) : dv0[16:0];
      ny1 <= du0[17];
      nz1 <= dv0[17];
      side1 <= side0;
      sy1 <= size_y;
      dyw1 <= {w0, 4'b0};
      dzh1 <= {h0, 4'b0};
    end
  end

  // stage 2: products
  ctl_t c2;
  logic [DivNumWidth-1:0] py2, pz2;
  logic ny2, nz2;
  logic [16:0] dy2, dz2;
  always_ff @(posedge clk) begin
    if (rst) begin
      c2.valid <= 1'b0;
    end else if (en) begin
      c2.valid <= c1.valid;
    end
    if (en) begin
      c2.flag <= c1.flag;
      c2.cyl <= c1.cyl;
      c2.face <= c1.face;
      c2.size_x <= c1.size_x;
      c2.offx <= c1.offx;
      c2.offz <= c1.offz;
      py2 <= DivNumWidth'(adu1 * side1);
      pz2 <= DivNumWidth'(adv1 * sy1);
      ny2 <= ny1;
      nz2 <= nz1;
      dy2 <= dyw1;
      dz2 <= dzh1;
    end
  end

  ctl_t dc [DivSteps+1];
  logic [DivNumWidth-1:0] dny [DivSteps+1], dry [DivSteps+1];
  logic [DivNumWidth-1:0] dnz [DivSteps+1], drz [DivSteps+1];
  logic [DivDenWidth-1:0] ddy [DivSteps+1], ddz [DivSteps+1];
  logic dgy [DivSteps+1], dgz [DivSteps+1];
  assign dc[0] = c2;
  assign dny[0] = py2;
  assign dry[0] = '0;
  assign ddy[0] = dy2;
  assign dgy[0] = ny2;
  assign dnz[0] = pz2;
  assign drz[0] = '0;
  assign ddz[0] = dz2;
  assign dgz[0] = nz2;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    fpoc_div_cell #(.Step(i)) u_cell (
      .clk(clk), .rst(rst), .en(en), .ctl_in(dc[i]),
      .num_y_in(dny[i]), .rem_y_in(dry[i]), .den_y_in(ddy[i]), .neg_y_in(dgy[i]),
      .num_z_in(dnz[i]), .rem_z_in(drz[i]), .den_z_in(ddz[i]), .neg_z_in(dgz[i]),
      .ctl_out(dc[i+1]),
      .num_y_out(dny[i+1]), .rem_y_out(dry[i+1]), .den_y_out(ddy[i+1]),
      .neg_y_out(dgy[i+1]),
      .num_z_out(dnz[i+1]), .rem_z_out(drz[i+1]), .den_z_out(ddz[i+1]),
      .neg_z_out(dgz[i+1])
    );
  end

  // stage: signed quotients, radicand
  ctl_t c3;
  logic signed [QuotWidth:0] ly3, lz3;
  logic [SqrtWidth-1:0] rad3;
  logic [QuotWidth-1:0] qy, qz;
  logic [DivNumWidth-1:0] ay_w;
  logic big_y;
  assign qy = dny[DivSteps][QuotWidth-1:0];
  assign qz = dnz[DivSteps][QuotWidth-1:0];
  assign ay_w = dny[DivSteps];
  assign big_y = ay_w > {{(DivNumWidth-24){1'b0}}, dc[DivSteps].size_x};
  always_ff @(posedge clk) begin
    if (rst) begin
      c3.valid <= 1'b0;
    end else if (en) begin
      c3.valid <= dc[DivSteps].valid;
    end
    if (en) begin
      c3.cyl <= dc[DivSteps].cyl;
      c3.face <= dc[DivSteps].face;
      c3.size_x <= dc[DivSteps].size_x;
      c3.offx <= dc[DivSteps].offx;
      c3.offz <= dc[DivSteps].offz;
      c3.flag <= dc[DivSteps].flag || (dc[DivSteps].cyl && big_y);
      ly3 <= dgy[DivSteps] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      lz3 <= dgz[DivSteps] ? $signed({1'b0, qz}) : -$signed({1'b0, qz});
      if (dc[DivSteps].cyl && !big_y) begin
        rad3 <= SqrtWidth'(dc[DivSteps].size_x * dc[DivSteps].size_x)
              - SqrtWidth'(ay_w[23:0] * ay_w[23:0]);
      end else begin
        rad3 <= '0;
      end
    end
  end

  ctl_t sc [SqrtSteps+1];
  logic [SqrtWidth-1:0] sn [SqrtSteps+1], sr [SqrtSteps+1];
  logic signed [QuotWidth:0] sly [SqrtSteps+1], slz [SqrtSteps+1];
  assign sc[0] = c3;
  assign sn[0] = rad3;
  assign sr[0] = '0;
  assign sly[0] = ly3;
  assign slz[0] = lz3;

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    fpoc_sqrt_cell #(.Step(j)) u_cell (
      .clk(clk), .rst(rst), .en(en), .ctl_in(sc[j]),
      .n_in(sn[j]), .res_in(sr[j]), .ly_in(sly[j]), .lz_in(slz[j]),
      .ctl_out(sc[j+1]), .n_out(sn[j+1]), .res_out(sr[j+1]),
      .ly_out(sly[j+1]), .lz_out(slz[j+1])
    );
  end

  // stage: face rotation
  ctl_t c4;
  logic signed [QuotWidth+1:0] gx4, gy4, gz4;
  logic signed [QuotWidth+1:0] lx, ly, ox, oz;
  assign lx = $signed({{(QuotWidth+2-SqrtWidth/2){1'b0}}, sr[SqrtSteps][SqrtWidth/2-1:0]});
  assign ly = (QuotWidth+2)'(sly[SqrtSteps]);
  assign ox = $signed({{(QuotWidth+2-24){1'b0}}, sc[SqrtSteps].offx});
  assign oz = $signed({{(QuotWidth+2-24){1'b0}}, sc[SqrtSteps].offz});
  always_ff @(posedge clk) begin
    if (rst) begin
      c4.valid <= 1'b0;
    end else if (en) begin
      c4.valid <= sc[SqrtSteps].valid;
    end
    if (en) begin
      c4.flag <= sc[SqrtSteps].flag;
      c4.cyl <= sc[SqrtSteps].cyl;
      c4.face <= sc[SqrtSteps].face;
      c4.size_x <= sc[SqrtSteps].size_x;
      c4.offx <= sc[SqrtSteps].offx;
      c4.offz <= sc[SqrtSteps].offz;
      gz4 <= (QuotWidth+2)'(slz[SqrtSteps]);
      case (sc[SqrtSteps].face)
        3'd0: begin gx4 <= lx + oz; gy4 <= ly; end
        3'd1: begin gx4 <= -ly; gy4 <= lx + ox; end
        3'd2: begin gx4 <= ly; gy4 <= -lx - ox; end
        3'd3: begin gx4 <= -lx - oz; gy4 <= -ly; end
        default: begin gx4 <= lx; gy4 <= ly; end
      endcase
    end
  end

  // output register with saturation
  localparam logic signed [QuotWidth+1:0] OMax = (QuotWidth+2)'(33554431);
  localparam logic signed [QuotWidth+1:0] OMin = -(QuotWidth+2)'(33554432);
  function automatic logic [OutWidth:0] sat(input logic signed [QuotWidth+1:0] v);
    logic [OutWidth:0] r;
    if (v > OMax) r = {1'b1, OMax[OutWidth-1:0]};
    else if (v < OMin) r = {1'b1, OMin[OutWidth-1:0]};
    else r = {1'b0, v[OutWidth-1:0]};
    return r;
  endfunction
  logic [OutWidth:0] sx, sy, sz;
  assign sx = sat(gx4);
  assign sy = sat(gy4);
  assign sz = sat(gz4);
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= c4.valid;
    end
    if (en) begin
      m_axis_tdata <= {2'b0, sz[OutWidth-1:0], sy[OutWidth-1:0], sx[OutWidth-1:0]};
      m_axis_tuser <= c4.flag | sx[OutWidth] | sy[OutWidth] | sz[OutWidth];
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready not tied to output stall");
  a_cylx: assert property (@(posedge clk) disable iff (rst)
    c4.valid && en && !c4.cyl && c4.face[2] |=> m_axis_tdata[25:0] == '0)
    else $error("box identity face gave nonzero x");
`endif
endmodule
